// ===== rtl/core/mco_pkg.sv =====
// Types, codes and the control program shared by the column operations core.
package mco_pkg;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_READ       = 3'd1,
    OP_SWAP       = 3'd2,
    OP_ADD        = 3'd3,
    OP_SCALE      = 3'd4,
    OP_ADD_SCALED = 3'd5
  } op_e;

  typedef enum logic [0:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 5;

  typedef struct packed {
    logic [2:0]         operation;
    logic [4:0]         first_column;
    logic [4:0]         second_column;
    logic signed [31:0] factor;
    logic [3:0]         element_row;
    logic [3:0]         element_column;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] read_value;
  } out_item_t;

  // Program steps of the sequencer.
  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_DONE     = 5'd1,
    ST_LOAD     = 5'd2,
    ST_READ     = 5'd3,
    ST_SWAP_RA  = 5'd4,
    ST_SWAP_RB  = 5'd5,
    ST_SWAP_WA  = 5'd6,
    ST_SWAP_WB  = 5'd7,
    ST_ADD_RA   = 5'd8,
    ST_ADD_RB   = 5'd9,
    ST_ADD_WA   = 5'd10,
    ST_SCL_RA   = 5'd11,
    ST_SCL_MUL  = 5'd12,
    ST_SCL_RND  = 5'd13,
    ST_SCL_WA   = 5'd14,
    ST_ASC_RB   = 5'd15,
    ST_ASC_RA   = 5'd16,
    ST_ASC_RND  = 5'd17,
    ST_ASC_WA   = 5'd18
  } step_e;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_A    = 2'd1,
    RD_B    = 2'd2,
    RD_ELEM = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_A    = 2'd1,
    WR_B    = 2'd2,
    WR_ELEM = 2'd3
  } wr_sel_e;

  typedef enum logic [2:0] {
    WS_ELEM   = 3'd0,
    WS_RDATA  = 3'd1,
    WS_VA     = 3'd2,
    WS_SUM_RD = 3'd3,
    WS_PQ     = 3'd4,
    WS_SUM_PQ = 3'd5
  } wsrc_e;

  typedef enum logic [1:0] {
    J_GOTO     = 2'd0,
    J_DISPATCH = 2'd1,
    J_LOOP     = 2'd2,
    J_FINISH   = 2'd3
  } jmp_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    wsrc_e   wsrc;
    logic    ld_va;
    logic    mul_en;
    logic    rnd_en;
    jmp_e    jmp;
    step_e   target;
  } uword_t;

  // Control signals from the sequencer to the datapath.
  typedef struct packed {
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    wsrc_e   wsrc;
    logic    ld_va;
    logic    mul_en;
    logic    rnd_en;
    logic    row_inc;
    logic    res_load;
    logic    idle;
  } seq_ctl_t;

  // Control store: one word per step.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      ST_IDLE:    w = '{RD_NONE, WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_DISPATCH, ST_IDLE};
      ST_DONE:    w = '{RD_NONE, WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_FINISH,   ST_IDLE};
      ST_LOAD:    w = '{RD_NONE, WR_ELEM, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_DONE};
      ST_READ:    w = '{RD_ELEM, WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_DONE};
      ST_SWAP_RA: w = '{RD_A,    WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_SWAP_RB};
      ST_SWAP_RB: w = '{RD_B,    WR_NONE, WS_ELEM,   1'b1, 1'b0, 1'b0, J_GOTO,     ST_SWAP_WA};
      ST_SWAP_WA: w = '{RD_NONE, WR_A,    WS_RDATA,  1'b0, 1'b0, 1'b0, J_GOTO,     ST_SWAP_WB};
      ST_SWAP_WB: w = '{RD_NONE, WR_B,    WS_VA,     1'b0, 1'b0, 1'b0, J_LOOP,     ST_SWAP_RA};
      ST_ADD_RA:  w = '{RD_A,    WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_ADD_RB};
      ST_ADD_RB:  w = '{RD_B,    WR_NONE, WS_ELEM,   1'b1, 1'b0, 1'b0, J_GOTO,     ST_ADD_WA};
      ST_ADD_WA:  w = '{RD_NONE, WR_A,    WS_SUM_RD, 1'b0, 1'b0, 1'b0, J_LOOP,     ST_ADD_RA};
      ST_SCL_RA:  w = '{RD_A,    WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_SCL_MUL};
      ST_SCL_MUL: w = '{RD_NONE, WR_NONE, WS_ELEM,   1'b0, 1'b1, 1'b0, J_GOTO,     ST_SCL_RND};
      ST_SCL_RND: w = '{RD_NONE, WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b1, J_GOTO,     ST_SCL_WA};
      ST_SCL_WA:  w = '{RD_NONE, WR_A,    WS_PQ,     1'b0, 1'b0, 1'b0, J_LOOP,     ST_SCL_RA};
      ST_ASC_RB:  w = '{RD_B,    WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_ASC_RA};
      ST_ASC_RA:  w = '{RD_A,    WR_NONE, WS_ELEM,   1'b0, 1'b1, 1'b0, J_GOTO,     ST_ASC_RND};
      ST_ASC_RND: w = '{RD_NONE, WR_NONE, WS_ELEM,   1'b1, 1'b0, 1'b1, J_GOTO,     ST_ASC_WA};
      ST_ASC_WA:  w = '{RD_NONE, WR_A,    WS_SUM_PQ, 1'b0, 1'b0, 1'b0, J_LOOP,     ST_ASC_RB};
      default:    w = '{RD_NONE, WR_NONE, WS_ELEM,   1'b0, 1'b0, 1'b0, J_GOTO,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mco_seq.sv =====
// Step counter and program sequencer of the column operations core.
module mco_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mco_pkg::step_e  entry_i,
  input  logic            rows_left_i,
  input  logic            out_free_i,
  output mco_pkg::seq_ctl_t ctl_o
);
  import mco_pkg::*;

  step_e  step_q, step_d;
  uword_t uw;

  assign uw = ucode(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Next step.
  always_comb begin
    step_d = step_q;
    case (uw.jmp)
      J_GOTO: begin
        step_d = uw.target;
      end
      J_DISPATCH: begin
        if (start_i) begin
          step_d = entry_i;
        end
      end
      J_LOOP: begin
        step_d = rows_left_i ? uw.target : ST_DONE;
      end
      J_FINISH: begin
        if (out_free_i) begin
          step_d = uw.target;
        end
      end
      default: begin
        step_d = ST_IDLE;
      end
    endcase
  end

  // Control word out to the datapath.
  always_comb begin
    ctl_o.rd_sel   = uw.rd_sel;
    ctl_o.wr_sel   = uw.wr_sel;
    ctl_o.wsrc     = uw.wsrc;
    ctl_o.ld_va    = uw.ld_va;
    ctl_o.mul_en   = uw.mul_en;
    ctl_o.rnd_en   = uw.rnd_en;
    ctl_o.row_inc  = (uw.jmp == J_LOOP) && rows_left_i;
    ctl_o.res_load = (uw.jmp == J_FINISH) && out_free_i;
    ctl_o.idle     = (uw.jmp == J_DISPATCH);
  end

endmodule

// ===== rtl/core/matrix_column_operations_core.sv =====
// Top level of the column operations core: store, datapath and item control.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_i  (mco_pkg::in_item_t)
//   out     | output    | out_valid_o / out_stall_i  | out_o (mco_pkg::out_item_t)
//   cfg     | input     | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// One item at a time; each program step touches the store at most once, so the row walk
// sets the pace.
// Rejected items and column operations with no rows in use go straight to the result;
// load and read make one store access first, and column operations walk the rows in use,
// each row through its read and write steps. The next item is taken in the idle step.
// Reset returns the sequencer to idle, drops the output valid and sets both count
// registers to 16; the store is not cleared, so an entry must be loaded before it is read.
// A stalled result is held in the output register while the next item is accepted; the
// sequencer waits in its last step only while that register is still full and stalled.
module matrix_column_operations_core #(
  parameter int unsigned MAX_ROWS    = 16,
  parameter int unsigned MAX_COLUMNS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mco_pkg::in_item_t               in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mco_pkg::out_item_t              out_o,
  input  logic                            cfg_we_i,
  input  logic [mco_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [mco_pkg::CfgDataW-1:0]    cfg_data_i
);
  import mco_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
  localparam logic [AW-1:0] NCol    = AW'(MAX_COLUMNS);
  localparam logic [8:0]    MaxRows = 9'(MAX_ROWS);
  localparam logic [8:0]    MaxCols = 9'(MAX_COLUMNS);

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  // Round half up to Q16.16, then saturate.
  function automatic logic signed [31:0] rnd_sat(logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [63:0] q;
    t = p + 64'sd32768;
    q = t >>> 16;
    if (q > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (q < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return q[31:0];
  endfunction

  seq_ctl_t ctl;

  logic [4:0]         row_count_q, column_count_q;
  logic               ok_q, rd_q;
  logic [CW-1:0]      a_q, b_q;
  logic [AW-1:0]      eaddr_q;
  logic [RCW-1:0]     rows_q;
  logic [RW-1:0]      row_q;
  logic signed [31:0] factor_q, eval_q;
  logic signed [31:0] rdata_q, va_q, pq_q;
  logic signed [63:0] prod_q;
  logic               out_valid_q;
  out_item_t          out_q;
  logic [31:0]        store_q [Depth];

  logic          in_acc, out_free, rows_left;
  logic [8:0]    rows_eff, cols_eff, a_idx, b_idx, er9, ec9;
  logic          a_ok, b_ok, f_ok, elem_ok, ok_d;
  step_e         entry;
  logic [RW-1:0] erow;
  logic [CW-1:0] ecol;
  logic [AW-1:0] addr_a, addr_b, raddr, waddr;
  logic          re, we;
  logic signed [31:0] wdata;

  assign in_stall_o = !ctl.idle;
  assign in_acc     = in_valid_i && ctl.idle;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rows_left  = (9'(row_q) + 9'd1) < 9'(rows_q);

  // Item checks and program entry.
  always_comb begin
    rows_eff = (9'(row_count_q) > MaxRows) ? MaxRows : 9'(row_count_q);
    cols_eff = (9'(column_count_q) > MaxCols) ? MaxCols : 9'(column_count_q);
    a_ok     = (in_i.first_column != 5'd0) && (9'(in_i.first_column) <= cols_eff);
    b_ok     = (in_i.second_column != 5'd0) && (9'(in_i.second_column) <= cols_eff);
    f_ok     = (in_i.factor != 32'sd0);
    er9      = 9'(in_i.element_row);
    ec9      = 9'(in_i.element_column);
    elem_ok  = (er9 < MaxRows) && (ec9 < MaxCols);
    a_idx    = 9'(in_i.first_column) - 9'd1;
    b_idx    = 9'(in_i.second_column) - 9'd1;
    erow     = er9[RW-1:0];
    ecol     = ec9[CW-1:0];
    ok_d     = 1'b0;
    entry    = ST_DONE;
    case (in_i.operation)
      OP_LOAD: begin
        ok_d  = elem_ok;
        entry = elem_ok ? ST_LOAD : ST_DONE;
      end
      OP_READ: begin
        ok_d  = elem_ok;
        entry = elem_ok ? ST_READ : ST_DONE;
      end
      OP_SWAP: begin
        ok_d  = a_ok && b_ok;
        entry = ST_SWAP_RA;
      end
      OP_ADD: begin
        ok_d  = a_ok && b_ok;
        entry = ST_ADD_RA;
      end
      OP_SCALE: begin
        ok_d  = a_ok && f_ok;
        b_idx = a_idx;
        entry = ST_SCL_RA;
      end
      OP_ADD_SCALED: begin
        ok_d  = a_ok && b_ok && f_ok;
        entry = ST_ASC_RB;
      end
      default: begin
        ok_d  = 1'b0;
        entry = ST_DONE;
      end
    endcase
    // A rejected item, or a column operation with an empty row range, goes straight to the result.
    if (!ok_d || (rows_eff == 9'd0)) begin
      if (in_i.operation != OP_LOAD && in_i.operation != OP_READ) begin
        entry = ST_DONE;
      end
    end
  end

  mco_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .entry_i     (entry),
    .rows_left_i (rows_left),
    .out_free_i  (out_free),
    .ctl_o       (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 5'd16;
      column_count_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q   <= 1'b0;
      rd_q   <= 1'b0;
      rows_q <= '0;
      row_q  <= '0;
    end else if (in_acc) begin
      ok_q   <= ok_d;
      rd_q   <= ok_d && (in_i.operation == OP_READ);
      rows_q <= rows_eff[RCW-1:0];
      row_q  <= '0;
    end else if (ctl.row_inc) begin
      row_q <= row_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q      <= a_idx[CW-1:0];
      b_q      <= b_idx[CW-1:0];
      eaddr_q  <= AW'(erow) * NCol + AW'(ecol);
      factor_q <= in_i.factor;
      eval_q   <= in_i.element_value;
    end
  end

  // Store addressing and write data.
  always_comb begin
    addr_a = AW'(row_q) * NCol + AW'(a_q);
    addr_b = AW'(row_q) * NCol + AW'(b_q);
    re     = (ctl.rd_sel != RD_NONE);
    we     = (ctl.wr_sel != WR_NONE);
    case (ctl.rd_sel)
      RD_A:    raddr = addr_a;
      RD_B:    raddr = addr_b;
      RD_ELEM: raddr = eaddr_q;
      default: raddr = addr_a;
    endcase
    case (ctl.wr_sel)
      WR_A:    waddr = addr_a;
      WR_B:    waddr = addr_b;
      WR_ELEM: waddr = eaddr_q;
      default: waddr = addr_a;
    endcase
    case (ctl.wsrc)
      WS_ELEM:   wdata = eval_q;
      WS_RDATA:  wdata = rdata_q;
      WS_VA:     wdata = va_q;
      WS_SUM_RD: wdata = sat_add(va_q, rdata_q);
      WS_PQ:     wdata = pq_q;
      WS_SUM_PQ: wdata = sat_add(va_q, pq_q);
      default:   wdata = eval_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= store_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_va) begin
      va_q <= rdata_q;
    end
    if (ctl.mul_en) begin
      prod_q <= rdata_q * factor_q;
    end
    if (ctl.rnd_en) begin
      pq_q <= rnd_sat(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.res_load) begin
      out_q.accepted   <= ok_q;
      out_q.read_value <= rd_q ? rdata_q : 32'sd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The store is never written while waiting for an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.idle |-> (ctl.wr_sel == WR_NONE))
    else $error("store written while idle");

  // A rejected item leaves the store untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctl.idle && !ok_q) |-> (ctl.wr_sel == WR_NONE))
    else $error("store written for a rejected item");

  // Column writes stay inside the rows in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctl.wr_sel == WR_A) || (ctl.wr_sel == WR_B)) |-> (9'(row_q) < 9'(rows_q)))
    else $error("column write beyond the rows in use");

  // A result only appears when the sequencer finishes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.res_load))
    else $error("result valid without a finished item");

  // A result is never loaded over one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule
